FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the parse cost engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an expression is never true while reset is released.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`endif

FILE: hw/rtl/mtpc_pkg.sv
// Package with shared constants, command codes and a status type.
package mtpc_pkg;

  // Default capacities.
  localparam int unsigned MaxStringLen = 256;
  localparam int unsigned MaxTokens    = 256;
  localparam int unsigned MaxTokenLen  = 16;

  // Command codes carried by func_i.
  typedef enum logic [2:0] {
    FuncTokByte = 3'd0,
    FuncTokEnd  = 3'd1,
    FuncStrByte = 3'd2,
    FuncStrEnd  = 3'd3,
    FuncClear   = 3'd4
  } func_e;

  // Status of the parse sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } pstat_t;

endpackage

FILE: hw/rtl/mtpc_parser.sv
// Storage and backward dynamic program sequencer of the parse cost engine.
`include "assert_macros.svh"

module mtpc_parser #(
  parameter int unsigned MAX_STRING_LEN = 256,
  parameter int unsigned MAX_TOKENS     = 256,
  parameter int unsigned MAX_TOKEN_LEN  = 16,
  localparam int unsigned SAW  = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1,
  localparam int unsigned SLW  = $clog2(MAX_STRING_LEN + 1),
  localparam int unsigned TIW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1,
  localparam int unsigned TCW  = $clog2(MAX_TOKENS + 1),
  localparam int unsigned LW   = $clog2(MAX_TOKEN_LEN + 1),
  localparam int unsigned TSD  = MAX_TOKENS * MAX_TOKEN_LEN,
  localparam int unsigned TSAW = (TSD > 1) ? $clog2(TSD) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_we_i,
  input  logic [TSAW-1:0]  tok_waddr_i,
  input  logic [7:0]       tok_wdata_i,
  input  logic             len_we_i,
  input  logic [TIW-1:0]   len_waddr_i,
  input  logic [LW-1:0]    len_wdata_i,
  input  logic             str_we_i,
  input  logic [SAW-1:0]   str_waddr_i,
  input  logic [7:0]       str_wdata_i,
  input  logic             go_i,
  input  logic [SLW-1:0]   str_len_i,
  input  logic [TCW-1:0]   tok_count_i,
  output mtpc_pkg::pstat_t stat_o,
  output logic [SLW-1:0]   cost_o
);
  import mtpc_pkg::*;

  localparam int unsigned TBW = $clog2(TSD + 1);

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StInit  = 12'b000000000010,
    StRow   = 12'b000000000100,
    StTlen  = 12'b000000001000,
    StTchk  = 12'b000000010000,
    StByte  = 12'b000000100000,
    StBcmp  = 12'b000001000000,
    StCread = 12'b000010000000,
    StCupd  = 12'b000100000000,
    StNext  = 12'b001000000000,
    StWrite = 12'b010000000000,
    StDone  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [SLW-1:0] n_q, n_d, i_q, i_d, best_q, best_d, prev_q, prev_d;
  logic [TCW-1:0] t_q, t_d;
  logic [TBW-1:0] tbase_q, tbase_d;
  logic [LW-1:0]  k_q, k_d, len_q, len_d;

  // Memories with registered read data.
  logic [7:0]     tok_mem  [TSD];
  logic [LW-1:0]  len_mem  [MAX_TOKENS];
  logic [7:0]     str_mem  [MAX_STRING_LEN];
  logic [SLW-1:0] cost_mem [MAX_STRING_LEN + 1];
  logic [7:0]     tok_rd_q, str_rd_q;
  logic [LW-1:0]  len_rd_q;
  logic [SLW-1:0] cost_rd_q;

  logic [31:0]    tok_raddr_w, str_raddr_w, cost_raddr_w, rem_w;
  logic [SLW-1:0] cost_waddr, cost_wdata;
  logic           cost_we;
  logic [SLW:0]   cand;

  assign tok_raddr_w  = 32'(tbase_q) + 32'(k_q);
  assign str_raddr_w  = 32'(i_q) + 32'(k_q);
  assign cost_raddr_w = 32'(i_q) + 32'(len_q);
  assign rem_w        = 32'(n_q) - 32'(i_q);
  assign cand         = {1'b0, cost_rd_q} + (SLW+1)'(1);

  // Cost table writes: the end entry at start, then one entry per position.
  assign cost_we    = (state_q == StInit) || (state_q == StWrite);
  assign cost_waddr = (state_q == StInit) ? n_q : i_q;
  assign cost_wdata = (state_q == StInit) ? '0 : best_q;

  always_ff @(posedge clk_i) begin
    if (tok_we_i) tok_mem[tok_waddr_i] <= tok_wdata_i;
    tok_rd_q <= tok_mem[tok_raddr_w[TSAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (len_we_i) len_mem[len_waddr_i] <= len_wdata_i;
    len_rd_q <= len_mem[t_q[TIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (str_we_i) str_mem[str_waddr_i] <= str_wdata_i;
    str_rd_q <= str_mem[str_raddr_w[SAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
    cost_rd_q <= cost_mem[cost_raddr_w[SLW-1:0]];
  end

  // Sequencer: positions from the end, tokens per position, bytes per token.
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    i_d     = i_q;
    best_d  = best_q;
    prev_d  = prev_q;
    t_d     = t_q;
    tbase_d = tbase_q;
    k_d     = k_q;
    len_d   = len_q;
    unique case (state_q)
      StIdle: begin
        if (go_i) begin
          n_d     = str_len_i;
          i_d     = str_len_i;
          prev_d  = '0;
          state_d = StInit;
        end
      end
      StInit: begin
        state_d = (n_q == '0) ? StDone : StRow;
      end
      StRow: begin
        i_d     = i_q - SLW'(1);
        best_d  = prev_q + SLW'(1);
        t_d     = '0;
        tbase_d = '0;
        state_d = (tok_count_i == '0) ? StWrite : StTlen;
      end
      StTlen: begin
        state_d = StTchk;
      end
      StTchk: begin
        if (len_rd_q == '0 || 32'(len_rd_q) > rem_w) begin
          state_d = StNext;
        end else begin
          len_d   = len_rd_q;
          k_d     = '0;
          state_d = StByte;
        end
      end
      StByte: begin
        state_d = StBcmp;
      end
      StBcmp: begin
        if (tok_rd_q != str_rd_q) begin
          state_d = StNext;
        end else if (k_q == len_q - LW'(1)) begin
          state_d = StCread;
        end else begin
          k_d     = k_q + LW'(1);
          state_d = StByte;
        end
      end
      StCread: begin
        state_d = StCupd;
      end
      StCupd: begin
        if (cand < {1'b0, best_q}) best_d = cand[SLW-1:0];
        state_d = StNext;
      end
      StNext: begin
        t_d     = t_q + TCW'(1);
        tbase_d = tbase_q + TBW'(MAX_TOKEN_LEN);
        state_d = (t_q + TCW'(1) == tok_count_i) ? StWrite : StTlen;
      end
      StWrite: begin
        prev_d  = best_q;
        state_d = (i_q == '0) ? StDone : StRow;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state is reset; the working values are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    best_q  <= best_d;
    prev_q  <= prev_d;
    t_q     <= t_d;
    tbase_q <= tbase_d;
    k_q     <= k_d;
    len_q   <= len_d;
  end

  assign stat_o.busy = (state_q != StIdle);
  assign stat_o.done = (state_q == StDone);
  assign cost_o      = prev_q;

  `ASSERT_PROP(done_then_idle_a, (state_q == StDone) |=> (state_q == StIdle),
               "Sequencer did not return to idle after a result.")
  `ASSERT_NEVER(byte_past_len_a, (state_q == StByte) && (k_q >= len_q),
                "Byte index ran past the token length.")
  `ASSERT_NEVER(row_at_start_a, (state_q == StRow) && (i_q == '0),
                "A position step started with no positions left.")

endmodule

FILE: hw/rtl/min_token_parse_cost.sv
// Top level: command decode, dictionary and string bookkeeping, totals and result.
// Token and string byte words do not raise busy; an end-of-string word keeps busy
// high while the single sequencer walks the string, checking each token byte by
// byte against each position and reading one byte pair a step.
// busy is high for the whole parse; the result strobe comes in the cycle after it.
// Reset clears the dictionary count, pending token and string, total and overflow.
`include "assert_macros.svh"

module min_token_parse_cost #(
  parameter int unsigned MAX_STRING_LEN = mtpc_pkg::MaxStringLen,
  parameter int unsigned MAX_TOKENS     = mtpc_pkg::MaxTokens,
  parameter int unsigned MAX_TOKEN_LEN  = mtpc_pkg::MaxTokenLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  output logic [8:0]  string_cost_o,
  output logic [31:0] running_total_o,
  output logic        overflow_o
);
  import mtpc_pkg::*;

  localparam int unsigned SAW  = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;
  localparam int unsigned SLW  = $clog2(MAX_STRING_LEN + 1);
  localparam int unsigned TIW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int unsigned TCW  = $clog2(MAX_TOKENS + 1);
  localparam int unsigned LW   = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned TSD  = MAX_TOKENS * MAX_TOKEN_LEN;
  localparam int unsigned TSAW = (TSD > 1) ? $clog2(TSD) : 1;
  localparam int unsigned TBW  = $clog2(TSD + 1);

  logic [TCW-1:0] tok_count_q, tok_count_d;
  logic [LW-1:0]  pend_q, pend_d;
  logic [TBW-1:0] wr_base_q, wr_base_d;
  logic [SLW-1:0] str_len_q, str_len_d;
  logic [31:0]    total_q, total_d;
  logic           ovf_q, ovf_d, valid_q;
  logic [8:0]     cost_out_q;

  logic           accept, tok_we, len_we, str_we, go;
  logic [31:0]    tok_waddr_w, cost32;
  logic [32:0]    sum;
  logic [SLW-1:0] cost;
  pstat_t         stat;

  assign accept      = start && !busy;
  assign busy        = stat.busy;
  assign tok_waddr_w = 32'(wr_base_q) + 32'(pend_q);
  assign cost32      = 32'(cost);
  assign sum         = {1'b0, total_q} + {1'b0, cost32};

  // Command decode and bookkeeping.
  always_comb begin
    tok_count_d = tok_count_q;
    pend_d      = pend_q;
    wr_base_d   = wr_base_q;
    str_len_d   = str_len_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    tok_we      = 1'b0;
    len_we      = 1'b0;
    str_we      = 1'b0;
    go          = 1'b0;
    if (accept) begin
      unique case (func_e'(func_i))
        FuncTokByte: begin
          if (32'(pend_q) >= 32'(MAX_TOKEN_LEN)) begin
            ovf_d = 1'b1;
          end else begin
            tok_we = (32'(tok_count_q) < 32'(MAX_TOKENS));
            pend_d = pend_q + LW'(1);
          end
        end
        FuncTokEnd: begin
          if (pend_q != '0) begin
            if (32'(tok_count_q) < 32'(MAX_TOKENS)) begin
              len_we      = 1'b1;
              tok_count_d = tok_count_q + TCW'(1);
              wr_base_d   = wr_base_q + TBW'(MAX_TOKEN_LEN);
            end else begin
              ovf_d = 1'b1;
            end
          end
          pend_d = '0;
        end
        FuncStrByte: begin
          if (32'(str_len_q) < 32'(MAX_STRING_LEN)) begin
            str_we    = 1'b1;
            str_len_d = str_len_q + SLW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        FuncStrEnd: begin
          go        = 1'b1;
          str_len_d = '0;
        end
        FuncClear: begin
          tok_count_d = '0;
          pend_d      = '0;
          wr_base_d   = '0;
          str_len_d   = '0;
          total_d     = '0;
          ovf_d       = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // Saturating accumulation when a parse finishes.
    if (stat.done) begin
      total_d = sum[32] ? '1 : sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_count_q <= '0;
      pend_q      <= '0;
      wr_base_q   <= '0;
      str_len_q   <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      tok_count_q <= tok_count_d;
      pend_q      <= pend_d;
      wr_base_q   <= wr_base_d;
      str_len_q   <= str_len_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      valid_q     <= stat.done;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (stat.done) cost_out_q <= cost32[8:0];
  end

  mtpc_parser #(
    .MAX_STRING_LEN (MAX_STRING_LEN),
    .MAX_TOKENS     (MAX_TOKENS),
    .MAX_TOKEN_LEN  (MAX_TOKEN_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_we_i    (tok_we),
    .tok_waddr_i (tok_waddr_w[TSAW-1:0]),
    .tok_wdata_i (data_byte_i),
    .len_we_i    (len_we),
    .len_waddr_i (tok_count_q[TIW-1:0]),
    .len_wdata_i (pend_q),
    .str_we_i    (str_we),
    .str_waddr_i (str_len_q[SAW-1:0]),
    .str_wdata_i (data_byte_i),
    .go_i        (go),
    .str_len_i   (str_len_q),
    .tok_count_i (tok_count_q),
    .stat_o      (stat),
    .cost_o      (cost)
  );

  assign valid_o         = valid_q;
  assign string_cost_o   = cost_out_q;
  assign running_total_o = total_q;
  assign overflow_o      = ovf_q;

  `ASSERT_PROP(strobe_single_a, valid_q |-> !$past(valid_q),
               "Result strobe held for more than one cycle.")
  `ASSERT_PROP(end_starts_parse_a, (accept && func_i == FuncStrEnd) |=> busy,
               "End of string did not start a parse.")
  `ASSERT_NEVER(pend_over_a, 32'(pend_q) > 32'(MAX_TOKEN_LEN),
                "Pending token length exceeds capacity.")

endmodule

FILE: tb/sv/tb_min_token_parse_cost.sv
// Testbench for the minimum-token parse cost engine: random and directed words, scoreboard check.
module tb_min_token_parse_cost;
  import mtpc_pkg::*;

  localparam int unsigned WdLimit = 400000;
  localparam int unsigned NumItems = 1350;

  typedef struct {
    logic [2:0] func;
    logic [7:0] data;
    bit         drain;
  } word_t;

  typedef struct {
    logic [8:0]  cost;
    logic [31:0] total;
    logic        ovf;
  } parse_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func_i = 3'd0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        valid_o;
  logic [8:0]  string_cost_o;
  logic [31:0] running_total_o;
  logic        overflow_o;

  min_token_parse_cost u_dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .data_byte_i,
    .valid_o, .string_cost_o, .running_total_o, .overflow_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  word_t      pending_words[$];
  parse_res_t expected_costs[$];
  int         error_count = 0;
  int         words_queued = 0;
  bit         quiet_tail = 1'b0;

  // Shadow copy of the engine state.
  logic [7:0]  sh_tok_bytes[MaxTokens*MaxTokenLen];
  int unsigned sh_tok_len[MaxTokens];
  int unsigned sh_tok_count, sh_pend_len, sh_str_len;
  logic [7:0]  sh_str[MaxStringLen];
  logic [31:0] sh_total;
  logic        sh_ovf;

  // Backward dynamic program over the stored string.
  function automatic int unsigned min_cover_cost();
    int unsigned suffix[MaxStringLen+1];
    int unsigned best, len, v;
    bit hit;
    suffix[sh_str_len] = 0;
    for (int i = int'(sh_str_len) - 1; i >= 0; i--) begin
      best = suffix[i+1] + 1;
      for (int t = 0; t < int'(sh_tok_count); t++) begin
        len = sh_tok_len[t];
        if (len == 0 || len > sh_str_len - i) continue;
        hit = 1'b1;
        for (int k = 0; k < int'(len); k++)
          if (sh_tok_bytes[t*MaxTokenLen+k] != sh_str[i+k]) hit = 1'b0;
        if (hit) begin
          v = suffix[i+len] + 1;
          if (v < best) best = v;
        end
      end
      suffix[i] = best;
    end
    return suffix[0];
  endfunction

  // Applies one accepted word to the shadow state, queuing any result.
  task automatic apply_word(logic [2:0] f, logic [7:0] b);
    parse_res_t r;
    int unsigned c;
    logic [32:0] sum;
    case (f)
      FuncTokByte: begin
        if (sh_pend_len >= MaxTokenLen) sh_ovf = 1'b1;
        else begin
          if (sh_tok_count < MaxTokens) sh_tok_bytes[sh_tok_count*MaxTokenLen+sh_pend_len] = b;
          sh_pend_len++;
        end
      end
      FuncTokEnd: begin
        if (sh_pend_len != 0) begin
          if (sh_tok_count < MaxTokens) begin
            sh_tok_len[sh_tok_count] = sh_pend_len;
            sh_tok_count++;
          end else sh_ovf = 1'b1;
        end
        sh_pend_len = 0;
      end
      FuncStrByte: begin
        if (sh_str_len < MaxStringLen) begin
          sh_str[sh_str_len] = b;
          sh_str_len++;
        end else sh_ovf = 1'b1;
      end
      FuncStrEnd: begin
        c = min_cover_cost();
        sum = {1'b0, sh_total} + c;
        sh_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        sh_str_len = 0;
        r.cost = c[8:0];
        r.total = sh_total;
        r.ovf = sh_ovf;
        expected_costs.push_back(r);
      end
      FuncClear: begin
        sh_tok_count = 0;
        sh_pend_len = 0;
        sh_str_len = 0;
        sh_total = '0;
        sh_ovf = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Driver: presents queued words, with random idle bursts.
  int idle_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        apply_word(func_i, data_byte_i);
        void'(pending_words.pop_front());
      end
      while (pending_words.size() > 0 && pending_words[0].drain && expected_costs.size() == 0
             && !(start && busy))
        void'(pending_words.pop_front());
      if (start && busy) begin
        // Word still waiting for acceptance: hold it.
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 16);
        start <= 1'b0;
      end else if (pending_words.size() > 0 && !pending_words[0].drain) begin
        start <= 1'b1;
        func_i <= pending_words[0].func;
        data_byte_i <= pending_words[0].data;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares each result strobe with the oldest expectation.
  always @(posedge clk_i) begin
    parse_res_t e;
    if (rst_ni && valid_o) begin
      if (expected_costs.size() == 0) begin
        report_mismatch("result count", 1, 0);
      end else begin
        e = expected_costs.pop_front();
        if (string_cost_o !== e.cost) report_mismatch("string_cost", string_cost_o, e.cost);
        if (running_total_o !== e.total)
          report_mismatch("running_total", running_total_o, e.total);
        if (overflow_o !== e.ovf) report_mismatch("overflow", overflow_o, e.ovf);
      end
    end
  end

  // Watchdog on cycles with no handshake and no result.
  int unsigned stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || !rst_ni || pending_words.size() == 0)
      stall_cycles <= 0;
    else if (stall_cycles >= WdLimit) begin
      $display("simulation failed");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  task automatic push_word(logic [2:0] f, logic [7:0] b);
    word_t w;
    w.func = f;
    w.data = b;
    w.drain = 1'b0;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_drain();
    word_t w;
    w.func = FuncClear;
    w.data = '0;
    w.drain = 1'b1;
    pending_words.push_back(w);
  endtask

  // Small alphabet so tokens actually match the strings.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 3));
  endfunction

  initial begin
    int dict_size, n, waited;
    sh_tok_count = 0; sh_pend_len = 0; sh_str_len = 0; sh_total = '0; sh_ovf = 1'b0;

    // Directed: empty string, empty token, unused codes, byte extremes.
    push_word(FuncStrEnd, 8'h00);
    push_word(FuncTokEnd, 8'h00);
    push_word(3'd5, 8'hFF);
    push_word(3'd6, 8'h00);
    push_word(3'd7, 8'hAA);
    push_word(FuncTokByte, 8'h00);
    push_word(FuncTokByte, 8'hFF);
    push_word(FuncTokEnd, 8'h55);
    push_word(FuncStrByte, 8'h00);
    push_word(FuncStrByte, 8'hFF);
    push_word(FuncStrByte, 8'h00);
    push_word(FuncStrEnd, 8'h00);
    // Token longer than the limit, then a string that uses it.
    for (int i = 0; i < 17; i++) push_word(FuncTokByte, 8'h41);
    push_word(FuncTokEnd, 8'h00);
    for (int i = 0; i < 18; i++) push_word(FuncStrByte, 8'h41);
    push_word(FuncStrEnd, 8'h00);
    push_drain();
    // Clear, then a full-length string with no tokens gives the widest cost.
    push_word(FuncClear, 8'hFF);
    for (int i = 0; i < 256; i++) push_word(FuncStrByte, 8'($urandom_range(0, 255)));
    push_word(FuncStrEnd, 8'h00);
    // String past the limit is truncated.
    push_word(FuncTokByte, 8'h42);
    push_word(FuncTokEnd, 8'h00);
    for (int i = 0; i < 258; i++) push_word(FuncStrByte, 8'h42);
    push_word(FuncStrEnd, 8'h00);
    // Dictionary fill past capacity.
    push_word(FuncClear, 8'h00);
    for (int i = 0; i < 257; i++) begin
      push_word(FuncTokByte, 8'(i));
      push_word(FuncTokEnd, 8'h00);
    end
    push_word(FuncStrByte, 8'h07);
    push_word(FuncStrByte, 8'hFE);
    push_word(FuncStrEnd, 8'h00);
    push_word(FuncClear, 8'h00);
    dict_size = 0;

    // Random: mostly well-formed dictionary and string sequences.
    while (words_queued < NumItems) begin
      if ($urandom_range(0, 9) < 7) begin
        if (dict_size > 8 || $urandom_range(0, 9) == 0) begin
          push_word(FuncClear, pick_byte());
          dict_size = 0;
        end
        repeat ($urandom_range(0, 3)) begin
          n = $urandom_range(1, 4);
          if ($urandom_range(0, 30) == 0) n = 17;
          repeat (n) push_word(FuncTokByte, pick_byte());
          push_word(FuncTokEnd, pick_byte());
          dict_size++;
        end
        repeat ($urandom_range(0, 20)) push_word(FuncStrByte, pick_byte());
        push_word(FuncStrEnd, pick_byte());
      end else begin
        repeat ($urandom_range(1, 3)) begin
          n = $urandom_range(0, 7);
          if (n == FuncTokEnd) dict_size++;
          push_word(3'(n), 8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 40) == 0) push_drain();
    end

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Last stretch runs with no idling.
    wait (pending_words.size() < 150);
    quiet_tail = 1'b1;
    wait (pending_words.size() == 0);
    waited = 0;
    while (expected_costs.size() != 0 && waited < WdLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (waited >= WdLimit) error_count++;
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && expected_costs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mtpc_pkg.sv
hw/rtl/mtpc_parser.sv
hw/rtl/min_token_parse_cost.sv
tb/sv/tb_min_token_parse_cost.sv
